// ===== rtl/mpad_pkg.sv =====
package mpad_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } mpad_state_t;

    // register indexes on the configuration port
    localparam logic [1:0] REG_POLE_LEVEL       = 2'd0;
    localparam logic [1:0] REG_EXCURSION_MIN    = 2'd1;
    localparam logic [1:0] REG_CROSSINGS_NEEDED = 2'd2;

    localparam logic [6:0] POLE_LEVEL_RST       = 7'd80;
    localparam logic [7:0] EXCURSION_MIN_RST    = 8'd10;
    localparam logic [4:0] CROSSINGS_NEEDED_RST = 5'd11;

    typedef struct packed {
        logic load_in;   // write the sample and start a scan
        logic issue;     // read one window entry
        logic load_out;  // move the scan result to the output register
    } mpad_cmd_t;

    typedef struct packed {
        logic scan_last; // read address is on the newest entry
        logic out_free;  // output register can take a result
    } mpad_status_t;

endpackage

// ===== rtl/mpad_ctrl.sv =====
module mpad_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mpad_pkg::mpad_status_t status,
    output mpad_pkg::mpad_cmd_t    cmd
);
    import mpad_pkg::*;

    mpad_state_t state_reg;
    mpad_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_FINISH: begin
                cmd.load_out = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/mpad_datapath.sv =====
module mpad_datapath #(
    parameter int WINDOW_LEN = 30
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mpad_pkg::mpad_cmd_t    cmd,
    output mpad_pkg::mpad_status_t status,
    input  logic [7:0]             sample,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [7:0]             cfg_wdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   north_pole,
    output logic                   south_pole,
    output logic                   alternating,
    output logic [4:0]             qualified_changes,
    output logic                   window_full
);
    import mpad_pkg::*;

    localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int EW = AW + 5;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_LEN - 1);

    // configuration
    logic [6:0] pole_level_reg;
    logic [7:0] excursion_min_reg;
    logic [4:0] crossings_needed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pole_level_reg       <= POLE_LEVEL_RST;
            excursion_min_reg    <= EXCURSION_MIN_RST;
            crossings_needed_reg <= CROSSINGS_NEEDED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_POLE_LEVEL:       pole_level_reg       <= cfg_wdata[6:0];
                REG_EXCURSION_MIN:    excursion_min_reg    <= cfg_wdata;
                REG_CROSSINGS_NEEDED: crossings_needed_reg <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // window memory and write side
    logic [7:0]    mem [WINDOW_LEN];
    logic [AW-1:0] wr_slot_reg;
    logic [AW-1:0] wr_slot_next;
    logic          filled_reg;

    assign wr_slot_next = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mem[wr_slot_reg] <= sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg <= '0;
            filled_reg  <= 1'b0;
        end else if (cmd.load_in) begin
            wr_slot_reg <= wr_slot_next;
            if (wr_slot_reg == LAST_SLOT) filled_reg <= 1'b1;
        end
    end

    // read side: scan starts at the oldest entry
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] scan_cnt_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_ok_reg;
    logic          rd_first_reg;
    logic          proc_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg  <= '0;
            scan_cnt_reg <= '0;
            proc_en_reg  <= 1'b0;
        end else begin
            proc_en_reg <= cmd.issue;
            if (cmd.load_in) begin
                rd_addr_reg  <= wr_slot_next;
                scan_cnt_reg <= '0;
            end else if (cmd.issue) begin
                rd_addr_reg  <= (rd_addr_reg == LAST_SLOT) ? '0 : rd_addr_reg + 1'b1;
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_data_reg  <= mem[rd_addr_reg];
            // entries never written since reset read as zero
            rd_ok_reg    <= filled_reg || (rd_addr_reg < wr_slot_reg);
            rd_first_reg <= (scan_cnt_reg == '0);
        end
    end

    assign status.scan_last = (scan_cnt_reg == LAST_SLOT);

    // scan accumulators
    logic signed [7:0] lo_reg;
    logic signed [7:0] hi_reg;
    logic signed [7:0] peak_reg;
    logic              tpos_reg;
    logic              tneg_reg;
    logic [AW-1:0]     count_reg;

    logic signed [7:0] v;
    logic              vpos;
    logic              vneg;
    logic signed [7:0] peak_upd;
    logic [7:0]        mag;
    logic              change;

    always_comb begin
        v        = rd_ok_reg ? $signed(rd_data_reg) : 8'sd0;
        vpos     = (v > 8'sd0);
        vneg     = v[7];
        peak_upd = ((tpos_reg && (v > peak_reg)) || (tneg_reg && (v < peak_reg))) ?
                   v : peak_reg;
        mag      = peak_upd[7] ? 8'(-peak_upd) : 8'(peak_upd);
        change   = (vpos && !tpos_reg) || (vneg && !tneg_reg);
    end

    always_ff @(posedge aclk) begin
        if (proc_en_reg) begin
            if (rd_first_reg) begin
                lo_reg    <= v;
                hi_reg    <= v;
                peak_reg  <= v;
                tpos_reg  <= vpos;
                tneg_reg  <= vneg;
                count_reg <= '0;
            end else begin
                if (v < lo_reg) lo_reg <= v;
                if (v > hi_reg) hi_reg <= v;
                if (change) begin
                    count_reg <= (mag >= excursion_min_reg) ? count_reg + 1'b1 : '0;
                    peak_reg  <= v;
                    tpos_reg  <= vpos;
                    tneg_reg  <= vneg;
                end else begin
                    peak_reg <= peak_upd;
                end
            end
        end
    end

    // output register
    logic          m_tvalid_reg;
    logic          north_reg;
    logic          south_reg;
    logic          alt_reg;
    logic [4:0]    qc_reg;
    logic          full_reg;
    logic [EW-1:0] count_ext;
    logic signed [8:0] hi_ext;
    logic signed [8:0] neg_pole;

    assign count_ext = EW'(count_reg);
    assign hi_ext    = {hi_reg[7], hi_reg};
    assign neg_pole  = -$signed({2'b00, pole_level_reg});

    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            north_reg <= filled_reg && (lo_reg > $signed({1'b0, pole_level_reg}));
            south_reg <= filled_reg && (hi_ext < neg_pole);
            alt_reg   <= (count_ext >= EW'(crossings_needed_reg));
            qc_reg    <= count_ext[4:0];
            full_reg  <= filled_reg;
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign north_pole        = north_reg;
    assign south_pole        = south_reg;
    assign alternating       = alt_reg;
    assign qualified_changes = qc_reg;
    assign window_full       = full_reg;

endmodule

// ===== rtl/magnetic_pole_alternation_detector.sv =====
// an accepted input beat starts a scan that reads one window entry per cycle
// through the single memory read port, followed by a drain state and a finish
// state that loads the output register once it is free; s_tready is low until then
// a finished result waits in the output register while the next beat is taken
// reset (aresetn, synchronous, active low) empties the window, restores the
// register defaults and drops m_tvalid
module magnetic_pole_alternation_detector #(
    parameter int WINDOW_LEN = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] field_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] north_pole, [1] south_pole, [2] alternating,
                                   // [7:3] qualified_changes, [8] window_full, rest zero
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import mpad_pkg::*;

    mpad_cmd_t    cmd;
    mpad_status_t status;
    logic         north_pole;
    logic         south_pole;
    logic         alternating;
    logic [4:0]   qualified_changes;
    logic         window_full;

    mpad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mpad_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .sample            (s_tdata),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .north_pole        (north_pole),
        .south_pole        (south_pole),
        .alternating       (alternating),
        .qualified_changes (qualified_changes),
        .window_full       (window_full)
    );

    assign m_tdata = {7'd0, window_full, qualified_changes, alternating,
                      south_pole, north_pole};

endmodule

// ===== test/tb_magnetic_pole_alternation_detector.sv =====
`timescale 1ns / 1ps

module tb_magnetic_pole_alternation_detector;
    import mpad_pkg::*;

    localparam int WIN         = 30;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_DIR       = 22;
    localparam int N_TYPED     = 3;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 250;

    // m_tdata layout, lowest bit is north
    typedef struct packed {
        logic [6:0] pad;
        logic       full;
        logic [4:0] changes;
        logic       alt;
        logic       south;
        logic       north;
    } pole_result_t;

    typedef enum int {
        GEN_NOISE,
        GEN_ALTERNATE,
        GEN_POLE,
        GEN_BOUNDARY
    } gen_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    magnetic_pole_alternation_detector #(
        .WINDOW_LEN(WIN)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic signed [7:0] win_q [WIN];
    int                slot_q;
    logic              filled_q;
    logic [6:0]        pole_lvl_q;
    logic [7:0]        exc_min_q;
    logic [4:0]        need_q;

    pole_result_t pole_expect_q[$];
    int           errors;
    int           cycles;

    // hand-typed expectation for the beat currently offered
    logic         want_typed;
    pole_result_t want_val;

    logic tx_burst;
    logic rx_burst;

    gen_mode_t gen_mode;
    int        gen_left;
    int        gen_pol;

    logic [7:0] dir_samples [N_DIR] = '{
        8'h00, 8'h7F, 8'h80, 8'h00, 8'h05, 8'hFB, 8'h09, 8'hF6, 8'h0A, 8'hF6, 8'h00,
        8'h00, 8'h01, 8'hFF, 8'h7F, 8'h80, 8'h7F, 8'hFF, 8'h01, 8'h55, 8'hAA, 8'h00
    };

    // first rows after reset: empty window, then a single qualified change
    pole_result_t dir_want [N_TYPED] = '{
        '{7'd0, 1'b0, 5'd0, 1'b0, 1'b0, 1'b0},
        '{7'd0, 1'b0, 5'd0, 1'b0, 1'b0, 1'b0},
        '{7'd0, 1'b0, 5'd1, 1'b0, 1'b0, 1'b0}
    };

    // raw write data per phase: pole level, excursion min, crossings needed
    logic [7:0] phase_cfg [6][3] = '{
        '{8'd0,   8'd0,   8'd0},
        '{8'd127, 8'd128, 8'd31},
        '{8'hFF,  8'd255, 8'd29},
        '{8'd40,  8'd129, 8'd1},
        '{8'd100, 8'd1,   8'hFF},
        '{8'd20,  8'd64,  8'd15}
    };

    function automatic int sign_of(input int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic pole_result_t scan_window(input logic [7:0] smp);
        pole_result_t res;
        int lo, hi, peak, tsign, count, idx, v, ns, mag;
        lo = 127;
        hi = -128;
        count = 0;
        win_q[slot_q] = smp;
        slot_q++;
        if (slot_q >= WIN) begin
            slot_q = 0;
            filled_q = 1'b1;
        end
        for (int i = 0; i < WIN; i++) begin
            v = win_q[i];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        // walk from the oldest entry to the newest
        peak = win_q[slot_q];
        tsign = sign_of(peak);
        for (int i = 0; i < WIN; i++) begin
            idx = (slot_q + i) % WIN;
            v = win_q[idx];
            if ((tsign > 0 && v > peak) || (tsign < 0 && v < peak)) peak = v;
            ns = sign_of(v);
            if (ns != 0 && ns != tsign) begin
                mag = (peak < 0) ? -peak : peak;
                if (mag >= int'(exc_min_q)) count++;
                else count = 0;
                peak = v;
                tsign = ns;
            end
        end
        res.pad     = '0;
        res.full    = filled_q;
        res.changes = count[4:0];
        res.alt     = (count >= int'(need_q));
        res.south   = filled_q && (hi < -int'(pole_lvl_q));
        res.north   = filled_q && (lo > int'(pole_lvl_q));
        return res;
    endfunction

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        pole_result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < WIN; i++) win_q[i] = '0;
            slot_q = 0;
            filled_q = 1'b0;
            pole_lvl_q = POLE_LEVEL_RST;
            exc_min_q = EXCURSION_MIN_RST;
            need_q = CROSSINGS_NEEDED_RST;
            pole_expect_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = pole_result_t'(m_tdata);
                if (pole_expect_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pole_expect_q.pop_front();
                    check_field("north_pole", want.north, got.north);
                    check_field("south_pole", want.south, got.south);
                    check_field("alternating", want.alt, got.alt);
                    check_field("qualified_changes", want.changes, got.changes);
                    check_field("window_full", want.full, got.full);
                    check_field("tdata padding", want.pad, got.pad);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_POLE_LEVEL:       pole_lvl_q = cfg_wdata[6:0];
                    REG_EXCURSION_MIN:    exc_min_q = cfg_wdata;
                    REG_CROSSINGS_NEEDED: need_q = cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = scan_window(s_tdata);
                pole_expect_q.push_back(want_typed ? want_val : want);
            end
        end
    end

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: random stalls with stretches of none
    initial begin
        int stall;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 47) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    task automatic send_sample(input logic [7:0] smp, input logic typed,
                               input pole_result_t want);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = smp;
        want_typed = typed;
        want_val = want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        // beat taken, do not offer it again
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pole_expect_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] next_sample();
        int cap, floor, mag, r;
        if (gen_left == 0) begin
            gen_mode = gen_mode_t'($urandom_range(0, 3));
            gen_left = $urandom_range(5, 60);
            gen_pol = $urandom_range(0, 1) ? 1 : -1;
        end
        gen_left--;
        if (gen_mode == GEN_NOISE) return 8'($urandom_range(0, 255));
        // mostly flip polarity so excursions alternate
        if (gen_mode != GEN_POLE && $urandom_range(0, 7) != 0) gen_pol = -gen_pol;
        cap = (gen_pol > 0) ? 127 : 128;
        r = $urandom_range(0, 19);
        case (gen_mode)
            GEN_ALTERNATE: begin
                floor = (int'(exc_min_q) > cap) ? cap : int'(exc_min_q);
                if (r == 0) mag = 0;
                else if (r == 1) mag = $urandom_range(0, floor);
                else mag = $urandom_range(floor, cap);
            end
            GEN_POLE: begin
                floor = int'(pole_lvl_q) + 1;
                if (floor > cap) floor = cap;
                if (r == 0) return 8'($urandom_range(0, 255));
                mag = $urandom_range(floor, cap);
            end
            default: begin
                // hug the excursion and pole thresholds
                if (r < 10) mag = int'(exc_min_q) + $urandom_range(0, 2) - 1;
                else mag = int'(pole_lvl_q) + $urandom_range(0, 2) - 1;
                if (mag < 0) mag = 0;
                if (mag > cap) mag = cap;
            end
        endcase
        return 8'(gen_pol * mag);
    endfunction

    initial begin
        logic [7:0] pcfg [3];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_POLE_LEVEL;
        cfg_wdata = '0;
        want_typed = 1'b0;
        want_val = '0;
        tx_burst = 1'b0;
        errors = 0;
        gen_mode = GEN_NOISE;
        gen_left = 0;
        gen_pol = 1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows run on the reset register values
        for (int i = 0; i < N_DIR; i++) begin
            if (i < N_TYPED) send_sample(dir_samples[i], 1'b1, dir_want[i]);
            else send_sample(dir_samples[i], 1'b0, '0);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            for (int r = 0; r < 3; r++) begin
                if (p < 6) pcfg[r] = phase_cfg[p][r];
                else pcfg[r] = 8'($urandom_range(0, 255));
            end
            write_reg(REG_POLE_LEVEL, pcfg[0]);
            write_reg(REG_EXCURSION_MIN, pcfg[1]);
            write_reg(REG_CROSSINGS_NEEDED, pcfg[2]);
            cfg_wr_en = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++) send_sample(next_sample(), 1'b0, '0);
        end
        s_tvalid = 1'b0;

        while (pole_expect_q.size() != 0) @(posedge aclk);
        repeat (WIN + 8) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
